>>> rtl/ccb_pkg.sv
// ccb_pkg: shared types, constants and limit functions for the clipped color-key blit
// used by ccb_scan, ccb_addr and clipped_color_key_blit; no dependencies

package ccb_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int DIM_W      = 12;
    localparam int CFG_DIM_W  = 13;
    localparam int OFS_W      = 14;
    localparam int POS_W      = 15;
    localparam int LINE_W     = 16;
    localparam int OFF_W      = 28;
    localparam int COLOR_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_DIM_W-1:0] MAX_DIM_C = CFG_DIM_W'(MAX_DIM);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH     = 3'd0,
        REG_SRC_HEIGHT    = 3'd1,
        REG_DST_WIDTH     = 3'd2,
        REG_DST_HEIGHT    = 3'd3,
        REG_OFFSET_X      = 3'd4,
        REG_OFFSET_Y      = 3'd5,
        REG_DST_LINE_SIZE = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [CFG_DIM_W-1:0]    src_w;
        logic [CFG_DIM_W-1:0]    src_h;
        logic [CFG_DIM_W-1:0]    dst_w;
        logic [CFG_DIM_W-1:0]    dst_h;
        logic signed [OFS_W-1:0] ofs_x;
        logic signed [OFS_W-1:0] ofs_y;
        logic [LINE_W-1:0]       row_bytes;
    } ccb_cfg_t;

    typedef struct packed {
        logic [DIM_W-1:0]   x;
        logic [DIM_W-1:0]   y;
        logic [COLOR_W-1:0] color;
    } ccb_hit_t;

    function automatic logic [CFG_DIM_W-1:0] limit_src(input logic [CFG_DIM_W-1:0] v);
        logic [CFG_DIM_W-1:0] r;
        if (v == '0)
            r = CFG_DIM_W'(1);
        else if (v > MAX_DIM_C)
            r = MAX_DIM_C;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [CFG_DIM_W-1:0] limit_dst(input logic [CFG_DIM_W-1:0] v);
        logic [CFG_DIM_W-1:0] r;
        if (v > MAX_DIM_C)
            r = MAX_DIM_C;
        else
            r = v;
        return r;
    endfunction

endpackage

>>> rtl/ccb_scan.sv
// ccb_scan: raster counters, destination mapping, clip and color-key test
// holds the first pipeline register; depends on ccb_pkg

module ccb_scan
    import ccb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  ccb_cfg_t           cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [COLOR_W-1:0] pixel_color,
    input  logic               adv,
    output logic               hit_valid,
    output ccb_hit_t           hit
);

    logic [DIM_W-1:0]        col_reg;
    logic [DIM_W-1:0]        col_next;
    logic [DIM_W-1:0]        row_reg;
    logic [DIM_W-1:0]        row_next;
    logic                    hit_valid_reg;
    logic                    hit_valid_next;
    ccb_hit_t                hit_reg;
    ccb_hit_t                hit_next;

    logic                    accept;
    logic signed [POS_W-1:0] dx;
    logic signed [POS_W-1:0] dy;
    logic [CFG_DIM_W-1:0]    dw;
    logic [CFG_DIM_W-1:0]    dh;
    logic [CFG_DIM_W-1:0]    sw;
    logic [CFG_DIM_W-1:0]    sh;
    logic [CFG_DIM_W-1:0]    col_inc;
    logic [CFG_DIM_W-1:0]    row_inc;
    logic                    in_hit;

    assign in_stall = hit_valid_reg && !adv;
    assign accept   = in_valid && !in_stall;

    assign dw = limit_dst(cfg.dst_w);
    assign dh = limit_dst(cfg.dst_h);
    assign sw = limit_src(cfg.src_w);
    assign sh = limit_src(cfg.src_h);

    // destination point, 15-bit signed covers counter plus any 14-bit offset
    assign dx = $signed({3'b000, col_reg}) + $signed({cfg.ofs_x[OFS_W-1], cfg.ofs_x});
    assign dy = $signed({3'b000, row_reg}) + $signed({cfg.ofs_y[OFS_W-1], cfg.ofs_y});

    assign in_hit = !dx[POS_W-1] && (dx[POS_W-2:0] < {1'b0, dw})
                 && !dy[POS_W-1] && (dy[POS_W-2:0] < {1'b0, dh})
                 && (pixel_color[COLOR_W-1:COLOR_W-8] == 8'h00);

    assign col_inc = {1'b0, col_reg} + CFG_DIM_W'(1);
    assign row_inc = {1'b0, row_reg} + CFG_DIM_W'(1);

    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        hit_valid_next = hit_valid_reg;
        hit_next       = hit_reg;
        if (accept)
        begin
            if (col_inc >= sw)
            begin
                col_next = '0;
                if (row_inc >= sh)
                    row_next = '0;
                else
                    row_next = row_inc[DIM_W-1:0];
            end
            else
            begin
                col_next = col_inc[DIM_W-1:0];
            end
            hit_valid_next = in_hit;
            hit_next.x     = dx[DIM_W-1:0];
            hit_next.y     = dy[DIM_W-1:0];
            hit_next.color = pixel_color;
        end
        else if (adv)
        begin
            hit_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            hit_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            hit_valid_reg <= hit_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg <= hit_next;
    end

    assign hit_valid = hit_valid_reg;
    assign hit       = hit_reg;

endmodule

>>> rtl/ccb_addr.sv
// ccb_addr: byte offset multiply-add and the result register
// depends on ccb_pkg

module ccb_addr
    import ccb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [LINE_W-1:0]  row_bytes,
    input  logic               hit_valid,
    input  ccb_hit_t           hit,
    output logic               adv,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [DIM_W-1:0]   out_x,
    output logic [DIM_W-1:0]   out_y,
    output logic [OFF_W-1:0]   byte_offset,
    output logic [COLOR_W-1:0] out_color
);

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [DIM_W-1:0]   x_reg;
    logic [DIM_W-1:0]   x_next;
    logic [DIM_W-1:0]   y_reg;
    logic [DIM_W-1:0]   y_next;
    logic [OFF_W-1:0]   off_reg;
    logic [OFF_W-1:0]   off_next;
    logic [COLOR_W-1:0] color_reg;
    logic [COLOR_W-1:0] color_next;
    logic [OFF_W-1:0]   prod;

    assign adv  = !out_valid_reg || !out_stall;
    assign prod = hit.y * row_bytes;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        off_next       = off_reg;
        color_next     = color_reg;
        if (adv)
        begin
            out_valid_next = hit_valid;
            x_next         = hit.x;
            y_next         = hit.y;
            off_next       = prod + {{(OFF_W-DIM_W-2){1'b0}}, hit.x, 2'b00};
            color_next     = hit.color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        off_reg   <= off_next;
        color_reg <= color_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_x       = x_reg;
    assign out_y       = y_reg;
    assign byte_offset = off_reg;
    assign out_color   = color_reg;

endmodule

>>> rtl/clipped_color_key_blit.sv
// clipped_color_key_blit: top level, configuration registers and the two pipeline stages
// depends on ccb_pkg, ccb_scan and ccb_addr
//
//   channel  handshake            payload
//   in       in_valid/in_stall    pixel_color
//   out      out_valid/out_stall  out_x, out_y, byte_offset, out_color
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one pixel per cycle while in_stall is low; a pixel goes to out via the hit register
// stage one maps and clips, stage two does the 12x16 multiply-add into the result register
// reset clears the column and row counters and loads the register reset values
// out_stall holds the result register; in_stall needs both stages full, out_stall high

module clipped_color_key_blit
    import ccb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [COLOR_W-1:0]    pixel_color,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DIM_W-1:0]      out_x,
    output logic [DIM_W-1:0]      out_y,
    output logic [OFF_W-1:0]      byte_offset,
    output logic [COLOR_W-1:0]    out_color,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CFG_DIM_W-1:0]    src_w_reg;
    logic [CFG_DIM_W-1:0]    src_h_reg;
    logic [CFG_DIM_W-1:0]    dst_w_reg;
    logic [CFG_DIM_W-1:0]    dst_h_reg;
    logic signed [OFS_W-1:0] ofs_x_reg;
    logic signed [OFS_W-1:0] ofs_y_reg;
    logic [LINE_W-1:0]       line_reg;

    ccb_cfg_t cfg;
    logic     adv;
    logic     hit_valid;
    ccb_hit_t hit;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= CFG_DIM_W'(1);
            src_h_reg <= CFG_DIM_W'(1);
            dst_w_reg <= '0;
            dst_h_reg <= '0;
            ofs_x_reg <= '0;
            ofs_y_reg <= '0;
            line_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SRC_WIDTH:     src_w_reg <= cfg_data[CFG_DIM_W-1:0];
                REG_SRC_HEIGHT:    src_h_reg <= cfg_data[CFG_DIM_W-1:0];
                REG_DST_WIDTH:     dst_w_reg <= cfg_data[CFG_DIM_W-1:0];
                REG_DST_HEIGHT:    dst_h_reg <= cfg_data[CFG_DIM_W-1:0];
                REG_OFFSET_X:      ofs_x_reg <= $signed(cfg_data[OFS_W-1:0]);
                REG_OFFSET_Y:      ofs_y_reg <= $signed(cfg_data[OFS_W-1:0]);
                REG_DST_LINE_SIZE: line_reg  <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign cfg.src_w     = src_w_reg;
    assign cfg.src_h     = src_h_reg;
    assign cfg.dst_w     = dst_w_reg;
    assign cfg.dst_h     = dst_h_reg;
    assign cfg.ofs_x     = ofs_x_reg;
    assign cfg.ofs_y     = ofs_y_reg;
    assign cfg.row_bytes = line_reg;

    ccb_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_color (pixel_color),
        .adv         (adv),
        .hit_valid   (hit_valid),
        .hit         (hit)
    );

    ccb_addr u_addr (
        .clk         (clk),
        .rst_n       (rst_n),
        .row_bytes   (line_reg),
        .hit_valid   (hit_valid),
        .hit         (hit),
        .adv         (adv),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_x       (out_x),
        .out_y       (out_y),
        .byte_offset (byte_offset),
        .out_color   (out_color)
    );

`ifndef NO_ASSERTIONS
    // backpressure on the input only comes from a held result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a held result");

    // transparent pixels never reach the second stage
    a_color_key: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (pixel_color[COLOR_W-1:COLOR_W-8] != 8'h00)) |=> !hit_valid)
        else $error("transparent pixel passed the color key");

    // an empty destination never produces a write
    a_empty_dst: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && ((dst_w_reg == '0) || (dst_h_reg == '0))) |=> !hit_valid)
        else $error("write produced for an empty destination");
`endif

endmodule

>>> tb/clipped_color_key_blit_test.sv
// clipped_color_key_blit_test: self-checking testbench for the clipped color-key blit
// predicts every destination write from its own copy of the counters and registers
// depends on ccb_pkg and clipped_color_key_blit

module clipped_color_key_blit_test;
    import ccb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_OUT_OF_RANGE = 3'd7;
    localparam int BYTES_PER_PIXEL = 4;
    localparam int DRAIN_CYCLES    = 8;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_PIXELS    = 150;
    localparam int MAX_REPORTS     = 10;

    typedef struct {
        logic [DIM_W-1:0]   x;
        logic [DIM_W-1:0]   y;
        logic [OFF_W-1:0]   offset;
        logic [COLOR_W-1:0] color;
    } blit_write_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [COLOR_W-1:0]    pixel_color = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [DIM_W-1:0]      out_x;
    logic [DIM_W-1:0]      out_y;
    logic [OFF_W-1:0]      byte_offset;
    logic [COLOR_W-1:0]    out_color;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of the registers and the scan counters
    logic [CFG_DIM_W-1:0]    src_w_r = CFG_DIM_W'(1);
    logic [CFG_DIM_W-1:0]    src_h_r = CFG_DIM_W'(1);
    logic [CFG_DIM_W-1:0]    dst_w_r = '0;
    logic [CFG_DIM_W-1:0]    dst_h_r = '0;
    logic signed [OFS_W-1:0] ofs_x_r = '0;
    logic signed [OFS_W-1:0] ofs_y_r = '0;
    logic [LINE_W-1:0]       line_r = '0;
    int                      src_col = 0;
    int                      src_row = 0;

    blit_write_t pending_writes[$];
    bit          idle_on = 1'b0;
    int          error_count = 0;
    int          pixels_sent = 0;
    int          writes_checked = 0;
    int          reg_writes = 0;
    int          settings_used = 0;

    clipped_color_key_blit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_color (pixel_color),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_x       (out_x),
        .out_y       (out_y),
        .byte_offset (byte_offset),
        .out_color   (out_color),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout with %0d writes still pending", pending_writes.size());
        $display("[clipped_color_key_blit] ERROR");
        $finish;
    end

    function automatic void report_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endfunction

    function automatic int clamp_dim(input logic [CFG_DIM_W-1:0] v, input bit zero_as_one);
        int r;
        r = int'(v);
        if (zero_as_one && r == 0)
            r = 1;
        if (r > MAX_DIM)
            r = MAX_DIM;
        return r;
    endfunction

    // maps one source pixel and queues the destination write it produces, if any
    function automatic void place_pixel(input logic [COLOR_W-1:0] color);
        int          dx;
        int          dy;
        int          dw;
        int          dh;
        int          sw;
        int          sh;
        logic [63:0] off;
        blit_write_t w;
        dx = src_col + int'(ofs_x_r);
        dy = src_row + int'(ofs_y_r);
        dw = clamp_dim(dst_w_r, 1'b0);
        dh = clamp_dim(dst_h_r, 1'b0);
        sw = clamp_dim(src_w_r, 1'b1);
        sh = clamp_dim(src_h_r, 1'b1);
        if (dx >= 0 && dx < dw && dy >= 0 && dy < dh && color[31:24] == 8'h00)
        begin
            off = 64'(dy) * 64'(line_r) + 64'(BYTES_PER_PIXEL * dx);
            w.x = DIM_W'(dx);
            w.y = DIM_W'(dy);
            w.offset = off[OFF_W-1:0];
            w.color = color;
            pending_writes.push_back(w);
        end
        src_col++;
        if (src_col >= sw)
        begin
            src_col = 0;
            src_row++;
            if (src_row >= sh)
                src_row = 0;
        end
    endfunction

    always @(posedge clk)
    begin : check_writes
        blit_write_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_writes.size() == 0)
                report_error($sformatf("unexpected write x=%0d y=%0d off=%h color=%h",
                                       out_x, out_y, byte_offset, out_color));
            else
            begin
                want = pending_writes.pop_front();
                writes_checked++;
                if (out_x !== want.x || out_y !== want.y || byte_offset !== want.offset
                    || out_color !== want.color)
                    report_error($sformatf(
                        "expected x=%0d y=%0d off=%h color=%h, got x=%0d y=%0d off=%h color=%h",
                        want.x, want.y, want.offset, want.color,
                        out_x, out_y, byte_offset, out_color));
            end
        end
        out_stall <= idle_on && ($urandom_range(0, 99) < 37);
    end

    task automatic send_pixel(input logic [COLOR_W-1:0] color);
        while (idle_on && $urandom_range(0, 99) < 37)
        begin
            in_valid <= 1'b0;
            pixel_color <= $urandom;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_color <= color;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        place_pixel(color);
        pixels_sent++;
    endtask

    // hold the stream until every queued write has come out, then let the pipe empty
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_SRC_WIDTH:     src_w_r = data[CFG_DIM_W-1:0];
            REG_SRC_HEIGHT:    src_h_r = data[CFG_DIM_W-1:0];
            REG_DST_WIDTH:     dst_w_r = data[CFG_DIM_W-1:0];
            REG_DST_HEIGHT:    dst_h_r = data[CFG_DIM_W-1:0];
            REG_OFFSET_X:      ofs_x_r = data[OFS_W-1:0];
            REG_OFFSET_Y:      ofs_y_r = data[OFS_W-1:0];
            REG_DST_LINE_SIZE: line_r = data;
            default:           ;
        endcase
        reg_writes++;
    endtask

    task automatic close_cfg();
        cfg_valid <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    task automatic program_regs(input logic [15:0] sw, input logic [15:0] sh,
                                input logic [15:0] dw, input logic [15:0] dh,
                                input logic [15:0] ox, input logic [15:0] oy,
                                input logic [15:0] ls);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_DST_WIDTH, dw);
        write_reg(REG_DST_HEIGHT, dh);
        write_reg(REG_OFFSET_X, ox);
        write_reg(REG_OFFSET_Y, oy);
        write_reg(REG_DST_LINE_SIZE, ls);
        close_cfg();
    endtask

    // reset values give an empty destination, so nothing is written
    task automatic test_empty_destination();
        send_pixel(32'h0000_0000);
        send_pixel(32'h00FF_FFFF);
        send_pixel(32'hFFFF_FFFF);
        settle();
    endtask

    // oversized destination clamps to the maximum, writes land on the far corner
    task automatic test_far_corner();
        program_regs(16'd2, 16'd2, 16'h1FFF, 16'hFFFF, 16'd4094, 16'd4094, 16'hFFFF);
        write_reg(REG_OUT_OF_RANGE, 16'hFFFF);
        close_cfg();
        send_pixel(32'h0000_0000);
        send_pixel(32'h00FF_FFFF);
        send_pixel(32'h00A5_A5A5);
        send_pixel(32'h005A_5A5A);
        settle();
    endtask

    // a negative x offset and a small destination clip the source on the left and bottom
    task automatic test_edge_clipping();
        program_regs(16'd3, 16'd2, 16'd2, 16'd1, 16'hFFFF, 16'd0, 16'd0);
        for (int i = 0; i < 6; i++)
            send_pixel({8'h00, 24'($urandom)});
        settle();
    endtask

    // zero source size acts as one, transparent keys and extreme offsets drop pixels
    task automatic test_degenerate_sizes();
        program_regs(16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd0, 16'd4);
        send_pixel(32'h0012_3456);
        send_pixel(32'h00ED_CBA9);
        send_pixel(32'h0100_0000);
        send_pixel(32'h8000_0000);
        settle();
        write_reg(REG_OFFSET_X, 16'h2000);
        write_reg(REG_OFFSET_Y, 16'hDFFF);
        close_cfg();
        send_pixel(32'h0000_0001);
        settle();
    endtask

    // shrinking the width mid-row wraps the counters without a reset
    task automatic test_midframe_resize();
        program_regs(16'd4, 16'd2, 16'h1FFF, 16'h1FFF, 16'd0, 16'd0, 16'd16);
        for (int i = 0; i < 3; i++)
            send_pixel({8'h00, 24'($urandom)});
        settle();
        write_reg(REG_SRC_WIDTH, 16'd2);
        close_cfg();
        for (int i = 0; i < 3; i++)
            send_pixel({8'h00, 24'($urandom)});
        settle();
    endtask

    function automatic logic [15:0] pick_src_dim();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'($urandom);
            2:       return 16'(MAX_DIM);
            default: return 16'($urandom_range(1, 24));
        endcase
    endfunction

    function automatic logic [15:0] pick_dst_dim();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'(MAX_DIM);
            default: return 16'($urandom_range(1, 32));
        endcase
    endfunction

    function automatic logic [15:0] pick_offset();
        int v;
        case ($urandom_range(0, 9))
            0:       v = int'($urandom);
            1:       v = MAX_DIM - int'($urandom_range(1, 20));
            default: v = int'($urandom_range(0, 20)) - 10;
        endcase
        return 16'(v);
    endfunction

    task automatic test_random_frames();
        logic [COLOR_W-1:0] color;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            idle_on = (phase != 1);
            program_regs(pick_src_dim(), pick_src_dim(), pick_dst_dim(), pick_dst_dim(),
                         pick_offset(), pick_offset(), 16'($urandom));
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg(REG_OUT_OF_RANGE, 16'($urandom));
                close_cfg();
            end
            for (int i = 0; i < PHASE_PIXELS; i++)
            begin
                if ($urandom_range(0, 3) != 0)
                    color = {8'h00, 24'($urandom)};
                else
                    color = $urandom;
                send_pixel(color);
            end
            settle();
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        idle_on = 1'b1;
        test_empty_destination();
        test_far_corner();
        test_edge_clipping();
        test_degenerate_sizes();
        test_midframe_resize();
        test_random_frames();
        settle();
        $display("sent %0d pixels and checked %0d writes over %0d register settings",
                 pixels_sent, writes_checked, settings_used);
        $display("%0d register writes, %0d mismatches", reg_writes, error_count);
        if (error_count == 0)
            $display("[clipped_color_key_blit] OK");
        else
            $display("[clipped_color_key_blit] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/ccb_pkg.sv
rtl/ccb_scan.sv
rtl/ccb_addr.sv
rtl/clipped_color_key_blit.sv
tb/clipped_color_key_blit_test.sv
